### sv/zcfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfm_pkg
// Shared constants, types and codes of the zero-crossing frequency meter.
// ----------------------------------------------------------------------------
package zcfm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_BLOCK  = 512;
    localparam int IDX_W      = 10;
    localparam int XIDX_W     = 9;
    localparam int TIME_W     = 26;
    localparam int SUM_W      = 27;
    localparam int PAIRS_W    = 9;
    localparam int RATE_W     = 18;
    localparam int OFFSET_W   = 32;
    localparam int FREQ_W     = 24;
    localparam int TUNE_W     = 33;
    localparam int CFG_W      = 32;
    localparam int CENTI_W    = 7;
    localparam int PROD1_W    = RATE_W + CENTI_W;
    localparam int PROD_W     = PROD1_W + PAIRS_W;
    localparam int OUT_DATA_W = 72;

    // shared divider geometry
    localparam int NUM_W      = 52;
    localparam int DEN_W      = 34;
    localparam int QUOT_W     = FREQ_W;
    localparam int XQ_STEPS   = FRAC_BITS + 1;
    localparam int FQ_STEPS   = FREQ_W;
    localparam int CNT_W      = 5;

    localparam logic [CENTI_W-1:0]  CENTI       = 7'd100;
    localparam logic [FREQ_W-1:0]   FREQ_MAX    = 24'hFFFFFF;
    localparam logic [RATE_W-1:0]   RATE_RST    = 18'd48000;
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = 32'd1407400000;

    typedef enum logic
    {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_TUNE_OFFSET = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        DIV_XING = 1'b0,
        DIV_FREQ = 1'b1
    } div_mode_t;

    typedef struct packed
    {
        logic                start;
        div_mode_t           mode;
        logic [NUM_W-1:0]    numer;
        logic [DEN_W-1:0]    denom;
    } div_req_t;

    typedef struct packed
    {
        logic                busy;
        logic                done;
        logic                ovf;
        logic [QUOT_W-1:0]   quot;
    } div_sts_t;

    typedef struct packed
    {
        logic [PAIRS_W-1:0]  pairs;
        logic [FREQ_W-1:0]   freq;
    } res_t;

    typedef enum logic [6:0]
    {
        ST_IDLE   = 7'b0000001,
        ST_XDIV   = 7'b0000010,
        ST_MUL1   = 7'b0000100,
        ST_MUL2   = 7'b0001000,
        ST_FSTART = 7'b0010000,
        ST_FDIV   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

endpackage

### sv/zcfm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfm_div
// Shared restoring divider, one quotient bit per cycle, with overflow check.
// ----------------------------------------------------------------------------
module zcfm_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  zcfm_pkg::div_req_t req,
    output zcfm_pkg::div_sts_t sts
);
    import zcfm_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dvd_reg, dvd_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic              first_reg, first_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        first_next = first_reg;

        if (req.start)
        begin
            den_next   = req.denom;
            quot_next  = '0;
            busy_next  = 1'b1;
            ovf_next   = 1'b0;
            first_next = 1'b1;
            if (req.mode == DIV_XING)
            begin
                rem_next = req.numer[DEN_W+XQ_STEPS-1:XQ_STEPS];
                dvd_next = {req.numer[XQ_STEPS-1:0], {(NUM_W-XQ_STEPS){1'b0}}};
                cnt_next = CNT_W'(XQ_STEPS);
            end
            else
            begin
                rem_next = {{(DEN_W-NUM_W+FQ_STEPS){1'b0}}, req.numer[NUM_W-1:FQ_STEPS]};
                dvd_next = {req.numer[FQ_STEPS-1:0], {(NUM_W-FQ_STEPS){1'b0}}};
                cnt_next = CNT_W'(FQ_STEPS);
            end
        end
        else if (busy_reg)
        begin
            // quotient too wide for the result field
            if (first_reg)
            begin
                ovf_next = (rem_reg >= den_reg);
            end
            first_next = 1'b0;
            rem_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd_next   = {dvd_reg[NUM_W-2:0], 1'b0};
            quot_next  = {quot_reg[QUOT_W-2:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign sts.quot = quot_reg;

endmodule

### sv/zcfm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zcfm_seq
// Sequencer: crossing detection, period accumulation and frequency steps.
// ----------------------------------------------------------------------------
module zcfm_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [zcfm_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic [zcfm_pkg::RATE_W-1:0]   rate,
    output zcfm_pkg::div_req_t            div_req,
    input  zcfm_pkg::div_sts_t            div_sts,
    output logic                          res_valid,
    input  logic                          res_ready,
    output zcfm_pkg::res_t                res
);
    import zcfm_pkg::*;

    state_t                 state_reg, state_next;
    logic [SAMPLE_W-1:0]    prev_reg, prev_next;
    logic                   have_prev_reg, have_prev_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   awaiting_reg, awaiting_next;
    logic [TIME_W-1:0]      start_reg, start_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [PAIRS_W-1:0]     count_reg, count_next;
    logic                   last_reg, last_next;
    logic [XIDX_W-1:0]      xidx_reg, xidx_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [FREQ_W-1:0]      freq_reg, freq_next;

    logic                   accept;
    logic                   idx_ok;
    logic                   xing;
    logic [SAMPLE_W-1:0]    mag;
    logic [SAMPLE_W:0]      den;
    logic [TIME_W-1:0]      t_cross;

    always_comb
    begin
        accept  = s_tvalid && s_tready;
        idx_ok  = (idx_reg < IDX_W'(MAX_BLOCK));
        xing    = idx_ok && have_prev_reg && (idx_reg != '0)
                  && prev_reg[SAMPLE_W-1] && !s_tdata[SAMPLE_W-1];
        mag     = ~prev_reg + 1'b1;
        den     = {s_tdata[SAMPLE_W-1], s_tdata} - {prev_reg[SAMPLE_W-1], prev_reg};
        t_cross = {1'b0, xidx_reg, {FRAC_BITS{1'b0}}}
                  + {{(TIME_W-XQ_STEPS){1'b0}}, div_sts.quot[XQ_STEPS-1:0]};

        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        idx_next       = idx_reg;
        awaiting_next  = awaiting_reg;
        start_next     = start_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        xidx_next      = xidx_reg;
        prod_next      = prod_reg;
        freq_next      = freq_reg;

        div_req.start  = 1'b0;
        div_req.mode   = DIV_XING;
        div_req.numer  = {{(NUM_W-SAMPLE_W-XQ_STEPS){1'b0}}, mag, {XQ_STEPS{1'b0}}}
                         + {{(NUM_W-SAMPLE_W-1){1'b0}}, den};
        div_req.denom  = {den, 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    prev_next      = s_tdata;
                    have_prev_next = 1'b1;
                    last_next      = s_tlast;
                    xidx_next      = XIDX_W'(idx_reg - 1'b1);
                    if (idx_ok)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    if (xing)
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_XDIV;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_XDIV:
            begin
                if (div_sts.done)
                begin
                    if (!awaiting_reg)
                    begin
                        start_next    = t_cross;
                        awaiting_next = 1'b1;
                    end
                    else
                    begin
                        sum_next      = sum_reg + {1'b0, t_cross - start_reg};
                        count_next    = count_reg + 1'b1;
                        awaiting_next = 1'b0;
                    end
                    state_next = last_reg ? ST_MUL1 : ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                prod_next  = {{PAIRS_W{1'b0}}, PROD1_W'(rate) * PROD1_W'(CENTI)};
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = prod_reg[PROD1_W-1:0] * count_reg;
                state_next = ST_FSTART;
            end
            ST_FSTART:
            begin
                div_req.mode  = DIV_FREQ;
                div_req.numer = {1'b0, prod_reg, {XQ_STEPS{1'b0}}}
                                + {{(NUM_W-SUM_W){1'b0}}, sum_reg};
                div_req.denom = {{(DEN_W-SUM_W-1){1'b0}}, sum_reg, 1'b0};
                if (count_reg == '0)
                begin
                    freq_next  = '0;
                    state_next = ST_OUT;
                end
                else if (sum_reg == '0)
                begin
                    freq_next  = FREQ_MAX;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                if (div_sts.done)
                begin
                    freq_next  = div_sts.ovf ? FREQ_MAX : div_sts.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    idx_next       = '0;
                    awaiting_next  = 1'b0;
                    start_next     = '0;
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            idx_reg       <= '0;
            awaiting_reg  <= 1'b0;
            start_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            idx_reg       <= idx_next;
            awaiting_reg  <= awaiting_next;
            start_reg     <= start_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xidx_reg <= xidx_next;
        prod_reg <= prod_next;
        freq_reg <= freq_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res.freq  = freq_reg;
    assign res.pairs = count_reg;

endmodule

### sv/zero_crossing_freq_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_freq_meter_unit
// Zero-crossing frequency meter: interpolated rising crossings, averaged
// period pairs, centihertz result and tuning word per sample block.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   32+1   tdata: sample[31:0]; tlast: last sample of block
//  m_axis    out  72     tdata: freq_centihz[23:0], tune_word[56:24],
//                               period_pairs[65:57], zero pad[71:66]
//  cfg       in   1+32   index 0 sample_rate_hz, index 1 tune_offset
//
//  a sample with no rising crossing is accepted while the sequencer stays idle
//  a crossing runs 17 quotient bits through the shared divider
//  the last sample adds two multiplies and, with non-zero pairs and sum, 24 quotient bits
//  s_tready is low while the divider or sequencer is busy with a beat
//  the result beat is held in an output register until taken
//  reset restores the register defaults and clears all block state at once
module zero_crossing_freq_meter_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [zcfm_pkg::SAMPLE_W-1:0]   s_tdata,   // sample
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [zcfm_pkg::OUT_DATA_W-1:0] m_tdata,   // freq, tune word, pairs
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [zcfm_pkg::CFG_W-1:0]      cfg_data
);
    import zcfm_pkg::*;

    logic [RATE_W-1:0]     rate_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    div_req_t              div_req;
    div_sts_t              div_sts;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    logic [TUNE_W-1:0]     tune;

    zcfm_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .sts     (div_sts)
    );

    zcfm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .rate      (rate_reg),
        .div_req   (div_req),
        .div_sts   (div_sts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RST;
            offset_reg <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_RATE: rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_TUNE_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:         rate_reg   <= rate_reg;
            endcase
        end
    end

    // output stage
    always_comb
    begin
        res_ready     = !m_tvalid_reg || m_tready;
        tune          = {{(TUNE_W-FREQ_W){1'b0}}, res.freq} + {1'b0, offset_reg};
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(OUT_DATA_W-PAIRS_W-TUNE_W-FREQ_W){1'b0}},
                             res.pairs, tune, res.freq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_ready_div_idle : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_sts.busy)
        else $error("input ready while divider busy");

    a_done_not_ready : assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> !s_tready)
        else $error("divider finished while sequencer idle");

    a_no_pairs_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[FREQ_W+TUNE_W+PAIRS_W-1:FREQ_W+TUNE_W] == '0))
        |-> (m_tdata[FREQ_W-1:0] == '0))
        else $error("non-zero frequency with no period pairs");

    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> m_tvalid)
        else $error("result beat not loaded into output register");

endmodule

### bench/zero_crossing_freq_meter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_freq_meter_unit_tb
// Streams blocks of audio samples into the frequency meter and checks every
// result beat against an in-bench model of the crossing interpolation, the
// period-pair averaging and the centihertz division. Covers directed corner
// blocks, register sweeps, an over-length block and random waveforms, with
// random idle cycles on both sides of the stream.
// ----------------------------------------------------------------------------
module zero_crossing_freq_meter_unit_tb;

    import zcfm_pkg::*;

    localparam int ITEM_GOAL   = 1780;
    localparam int BLOCK_GOAL  = 40;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct
    {
        logic [FREQ_W-1:0]  freq;
        logic [TUNE_W-1:0]  tune;
        logic [PAIRS_W-1:0] pairs;
    } meter_result_t;

    typedef logic [SAMPLE_W-1:0] sample_list_t[$];

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = CFG_SAMPLE_RATE;
    logic [CFG_W-1:0]      cfg_data = '0;

    // meter model state
    logic [RATE_W-1:0]   meter_rate = RATE_RST;
    logic [OFFSET_W-1:0] meter_offset = OFFSET_RST;
    longint              last_smp = 0;
    bit                  have_last = 1'b0;
    int unsigned         smp_idx = 0;
    bit                  in_period = 1'b0;
    longint unsigned     period_start = 0;
    longint unsigned     period_acc = 0;
    int unsigned         pairs_seen = 0;

    meter_result_t pending_results[$];

    bit gaps_on = 1'b1;
    int ready_hold = 0;
    int errors = 0;
    int samples_sent = 0;
    int blocks_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;

    zero_crossing_freq_meter_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("zero_crossing_freq_meter_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------ model

    function automatic longint unsigned crossing_at(input int unsigned idx,
                                                    input longint x0, input longint x1);
        longint unsigned num;
        longint unsigned den;
        longint unsigned frac;
        num  = -x0;
        den  = x1 - x0;
        frac = ((num << (FRAC_BITS + 1)) + den) / (den * 2);
        return (longint'(idx) << FRAC_BITS) + frac;
    endfunction

    function automatic logic [FREQ_W-1:0] centihz_estimate();
        longint unsigned num;
        longint unsigned q;
        if (pairs_seen == 0)
        begin
            return '0;
        end
        if (period_acc == 0)
        begin
            return FREQ_MAX;
        end
        num = 64'd100 * meter_rate;
        num = (num * pairs_seen) << FRAC_BITS;
        q = (num * 2 + period_acc) / (period_acc * 2);
        return (q > FREQ_MAX) ? FREQ_MAX : q[FREQ_W-1:0];
    endfunction

    task automatic predict_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        longint          x;
        longint unsigned t;
        meter_result_t   r;
        x = longint'($signed(smp));
        if (smp_idx < MAX_BLOCK)
        begin
            if (have_last && smp_idx > 0 && last_smp < 0 && x >= 0)
            begin
                t = crossing_at(smp_idx - 1, last_smp, x);
                if (!in_period)
                begin
                    period_start = t;
                    in_period = 1'b1;
                end
                else
                begin
                    period_acc += t - period_start;
                    pairs_seen++;
                    in_period = 1'b0;
                end
            end
            smp_idx++;
        end
        last_smp = x;
        have_last = 1'b1;
        if (lst)
        begin
            r.freq  = centihz_estimate();
            r.tune  = {9'd0, r.freq} + {1'b0, meter_offset};
            r.pairs = pairs_seen[PAIRS_W-1:0];
            pending_results.push_back(r);
            last_smp = 0;
            have_last = 1'b0;
            smp_idx = 0;
            in_period = 1'b0;
            period_start = 0;
            period_acc = 0;
            pairs_seen = 0;
        end
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        int gap;
        gap = gaps_on ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_sample(smp, lst);
        samples_sent++;
        if (lst)
        begin
            blocks_sent++;
        end
    endtask

    task automatic send_run(input sample_list_t run);
        foreach (run[i])
        begin
            send_sample(run[i], i == run.size() - 1);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
        begin
            meter_rate = value[RATE_W-1:0];
        end
        else
        begin
            meter_offset = value;
        end
        reg_writes++;
    endtask

    // ---------------------------------------------------------------- checker

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("error at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        meter_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected result beat", 0, 64'(m_tdata[65:0]));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[23:0] !== want.freq)
                begin
                    note_mismatch("freq_centihz", want.freq, m_tdata[23:0]);
                end
                if (m_tdata[56:24] !== want.tune)
                begin
                    note_mismatch("tune_word", want.tune, m_tdata[56:24]);
                end
                if (m_tdata[65:57] !== want.pairs)
                begin
                    note_mismatch("period_pairs", want.pairs, m_tdata[65:57]);
                end
                if (m_tdata[71:66] !== 6'd0)
                begin
                    note_mismatch("tdata padding", 0, m_tdata[71:66]);
                end
            end
            ready_hold = gaps_on ? $urandom_range(0, 18) : 0;
        end
    end

    // ------------------------------------------------------------------ tests

    task automatic test_default_blocks();
        sample_list_t run;
        run = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                32'hFFFF_FFFE, 32'h0000_0003, 32'h0000_0000};
        send_run(run);
        run = '{32'd5, 32'd7, 32'd0};
        send_run(run);
        run = '{32'h8000_0000};
        send_run(run);
    endtask

    // one-sample periods at the top rate push the quotient past 24 bits
    task automatic test_saturation();
        sample_list_t run;
        drain_results();
        write_reg(CFG_SAMPLE_RATE, 32'd192000);
        write_reg(CFG_TUNE_OFFSET, 32'hFFFF_FFFF);
        run = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        send_run(run);
    endtask

    task automatic test_zero_rate();
        sample_list_t run;
        drain_results();
        write_reg(CFG_SAMPLE_RATE, 32'd0);
        run = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        send_run(run);
    endtask

    task automatic test_low_rate();
        sample_list_t run;
        drain_results();
        write_reg(CFG_SAMPLE_RATE, 32'd1);
        write_reg(CFG_TUNE_OFFSET, 32'd0);
        run = '{-32'sd100, 32'd100, -32'sd100, 32'd100};
        send_run(run);
    endtask

    // alternating signs well past the block limit: crossings beyond it are ignored
    task automatic test_long_block();
        longint v;
        drain_results();
        write_reg(CFG_SAMPLE_RATE, 32'd48000);
        write_reg(CFG_TUNE_OFFSET, 32'd1407400000);
        for (int i = 0; i < MAX_BLOCK + 8; i++)
        begin
            if (i % 2 == 0)
            begin
                v = -longint'($urandom_range(1, 32'h8000_0000));
            end
            else
            begin
                v = $urandom_range(0, 32'h7FFF_FFFF);
            end
            send_sample(v[SAMPLE_W-1:0], i == MAX_BLOCK + 7);
        end
    endtask

    task automatic test_random_blocks();
        int     kind;
        int     len;
        int     per;
        int     ph;
        int     amp_bits;
        int     blk;
        longint amp;
        longint dc;
        longint jit;
        longint v;
        blk = 0;
        while (samples_sent < ITEM_GOAL || blocks_sent < BLOCK_GOAL)
        begin
            if (blk % 8 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (blk % 15 == 14)
            begin
                drain_results();
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_SAMPLE_RATE, 32'd1);
                    1: write_reg(CFG_SAMPLE_RATE, 32'd192000);
                    2: write_reg(CFG_SAMPLE_RATE, 32'd44100);
                    3: write_reg(CFG_SAMPLE_RATE, 32'd0);
                    default: write_reg(CFG_SAMPLE_RATE, $urandom_range(1, 192000));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_TUNE_OFFSET, 32'd0);
                    1: write_reg(CFG_TUNE_OFFSET, 32'hFFFF_FFFF);
                    2: write_reg(CFG_TUNE_OFFSET, 32'd1407400000);
                    default: write_reg(CFG_TUNE_OFFSET, $urandom());
                endcase
            end
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
            per = $urandom_range(2, 24);
            ph = $urandom_range(0, per - 1);
            amp_bits = $urandom_range(1, 31);
            amp = (longint'(1) << amp_bits) - 1;
            dc = longint'($urandom_range(0, 64)) - 32;
            for (int i = 0; i < len; i++)
            begin
                if (kind < 7)
                begin
                    jit = ((amp >> 3) == 0) ? 0 :
                          longint'($urandom_range(0, 32'(amp >> 3))) - (amp >> 4);
                    v = -amp + (2 * amp * ph) / (per - 1) + dc + jit;
                    if (v > 64'sd2147483647)
                    begin
                        v = 64'sd2147483647;
                    end
                    if (v < -64'sd2147483648)
                    begin
                        v = -64'sd2147483648;
                    end
                    ph = (ph + 1) % per;
                end
                else if (kind < 9)
                begin
                    v = longint'($signed($urandom()));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: v = -1;
                        1: v = 0;
                        2: v = -64'sd2147483648;
                        default: v = 64'sd2147483647;
                    endcase
                end
                send_sample(v[SAMPLE_W-1:0], i == len - 1);
            end
            blk++;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_blocks();
        test_saturation();
        test_zero_rate();
        test_low_rate();
        test_long_block();
        test_random_blocks();
        drain_results();
        $display("sent %0d samples in %0d blocks, checked %0d result beats, %0d register writes",
                 samples_sent, blocks_sent, results_seen, reg_writes);
        $display("covered saturation, zero rate, over-length block, noise and waveforms; %0d mismatches",
                 errors);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("zero_crossing_freq_meter_unit: match");
        end
        else
        begin
            $display("zero_crossing_freq_meter_unit: mismatch");
        end
        $finish;
    end

endmodule

### files.f
sv/zcfm_pkg.sv
sv/zcfm_div.sv
sv/zcfm_seq.sv
sv/zero_crossing_freq_meter_unit.sv
bench/zero_crossing_freq_meter_unit_tb.sv
